[sv/tpf_pkg.sv]
package tpf_pkg;

    // Configuration register indexes.
    localparam logic [7:0] REG_FORCE_MAGNITUDE = 8'd0;
    localparam logic [7:0] REG_SELECTED_TYPE   = 8'd1;

    // Reset values of the configuration registers.
    localparam logic [31:0] FORCE_MAGNITUDE_RESET = 32'h0001_0000;
    localparam logic [7:0]  SELECTED_TYPE_RESET   = 8'd1;

    // Square root: one result bit per step, two steps per stage.
    localparam int SQRT_STEPS     = 32;
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

    // Divider: one quotient bit per step, two steps per stage.
    localparam int DIV_STEPS     = 34;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

    // Side data that travels with the sum of squares.
    typedef struct packed {
        logic [19:0]      center;
        logic [2:0]       neg;
        logic [2:0][30:0] mag;
    } side_t;

    // Side data that travels with the quotients.
    typedef struct packed {
        logic [19:0] center;
        logic [2:0]  sgn;
    } dside_t;

endpackage

[sv/tangent_propulsion_force.sv]
// Path: prep stages A to E, square root, product stages m1 and m2, divider, output register.
// Throughput: one transaction per cycle while the output is not held; the square root
// (16 stages) and the divider (17 stages) each retire two bits per stage.
// A held output stalls the whole pipeline in place; records that give no force leave no result.
// Reset (rst_n, asynchronous, active low) clears all valid bits and loads the
// configuration registers with magnitude 1.0 and selected type 1.
module tangent_propulsion_force #(
    parameter int ATOM_COUNT = 1048576
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_addr,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          angle_kind,
    input  logic [19:0]         center_atom,
    input  logic                center_in_group,
    input  logic signed [31:0]  first_pos_x,
    input  logic signed [31:0]  first_pos_y,
    input  logic signed [31:0]  first_pos_z,
    input  logic signed [31:0]  second_pos_x,
    input  logic signed [31:0]  second_pos_y,
    input  logic signed [31:0]  second_pos_z,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [19:0]         target_atom,
    output logic signed [31:0]  force_x,
    output logic signed [31:0]  force_y,
    output logic signed [31:0]  force_z
);

    logic [31:0] force_magnitude_reg;
    logic [7:0]  selected_type_reg;
    logic        en;

    logic           s_valid;
    logic [63:0]    s_sum;
    tpf_pkg::side_t s_side;

    logic           r_valid;
    logic [31:0]    r_root;
    tpf_pkg::side_t r_side;

    logic             m1_valid_reg;
    logic [2:0][62:0] m1_prod_reg;
    logic [31:0]      m1_root_reg;
    tpf_pkg::dside_t  m1_side_reg;

    logic             m2_valid_reg;
    logic [2:0][63:0] m2_num_reg;
    logic [31:0]      m2_root_reg;
    tpf_pkg::dside_t  m2_side_reg;

    logic             q_valid;
    logic [2:0][33:0] q_quot;
    tpf_pkg::dside_t  q_side;

    logic             out_valid_reg;
    logic [19:0]      out_atom_reg;
    logic [2:0][31:0] out_force_reg;
    logic [2:0][31:0] out_force_next;

    logic        fm_neg;
    logic [31:0] fm_abs;

    // The pipeline advances unless a result is held at the output.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_magnitude_reg <= tpf_pkg::FORCE_MAGNITUDE_RESET;
            selected_type_reg   <= tpf_pkg::SELECTED_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tpf_pkg::REG_FORCE_MAGNITUDE: force_magnitude_reg <= cfg_wdata;
                tpf_pkg::REG_SELECTED_TYPE:   selected_type_reg   <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    tpf_prep #(
        .ATOM_COUNT(ATOM_COUNT)
    ) u_prep (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (in_valid),
        .sel_type        (selected_type_reg),
        .angle_kind      (angle_kind),
        .center_atom     (center_atom),
        .center_in_group (center_in_group),
        .first_pos_x     (first_pos_x),
        .first_pos_y     (first_pos_y),
        .first_pos_z     (first_pos_z),
        .second_pos_x    (second_pos_x),
        .second_pos_y    (second_pos_y),
        .second_pos_z    (second_pos_z),
        .s_valid         (s_valid),
        .s_sum           (s_sum),
        .s_side          (s_side)
    );

    tpf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .in_sum    (s_sum),
        .in_side   (s_side),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    // Magnitude of the configured strength; -2^31 maps to 2^31.
    assign fm_neg = force_magnitude_reg[31];
    assign fm_abs = fm_neg ? (32'd0 - force_magnitude_reg) : force_magnitude_reg;

    // Valid bits of the product stages and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m1_valid_reg  <= r_valid;
            m2_valid_reg  <= m1_valid_reg;
            out_valid_reg <= q_valid;
        end
    end

    // Products with the strength, then the rounding offset of half the root.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_prod_reg[i]    <= 63'(fm_abs) * 63'(r_side.mag[i]);
                m1_side_reg.sgn[i] <= fm_neg ^ r_side.neg[i];
                m2_num_reg[i]     <= {1'b0, m1_prod_reg[i]} + {33'b0, m1_root_reg[31:1]};
            end
            m1_root_reg        <= r_root;
            m1_side_reg.center <= r_side.center;
            m2_root_reg        <= m1_root_reg;
            m2_side_reg        <= m1_side_reg;
        end
    end

    tpf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m2_valid_reg),
        .in_num    (m2_num_reg),
        .in_den    (m2_root_reg),
        .in_side   (m2_side_reg),
        .out_valid (q_valid),
        .out_quot  (q_quot),
        .out_side  (q_side)
    );

    // Sign of each component; positive quotients saturate at 2^31-1.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (q_quot[i] == 34'd0)
            begin
                out_force_next[i] = 32'd0;
            end
            else if (q_side.sgn[i])
            begin
                out_force_next[i] = 32'd0 - q_quot[i][31:0];
            end
            else if (q_quot[i] > 34'h0_7FFF_FFFF)
            begin
                out_force_next[i] = 32'h7FFF_FFFF;
            end
            else
            begin
                out_force_next[i] = q_quot[i][31:0];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_atom_reg  <= q_side.center;
            out_force_reg <= out_force_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign target_atom = out_atom_reg;
    assign force_x     = out_force_reg[0];
    assign force_y     = out_force_reg[1];
    assign force_z     = out_force_reg[2];

endmodule

[sv/tpf_prep.sv]
module tpf_prep #(
    parameter int ATOM_COUNT = 1048576
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [7:0]           sel_type,
    input  logic [7:0]           angle_kind,
    input  logic [19:0]          center_atom,
    input  logic                 center_in_group,
    input  logic signed [31:0]   first_pos_x,
    input  logic signed [31:0]   first_pos_y,
    input  logic signed [31:0]   first_pos_z,
    input  logic signed [31:0]   second_pos_x,
    input  logic signed [31:0]   second_pos_y,
    input  logic signed [31:0]   second_pos_z,
    output logic                 s_valid,
    output logic [63:0]          s_sum,
    output tpf_pkg::side_t       s_side
);

    // Stage A: filter and separation vector.
    logic             a_valid_reg, a_valid_next;
    logic [19:0]      a_center_reg;
    logic [2:0][32:0] a_d_reg;

    // Stage B: magnitudes, signs and largest magnitude.
    logic             b_valid_reg;
    logic [19:0]      b_center_reg;
    logic [2:0]       b_neg_reg;
    logic [2:0][32:0] b_mag_reg;
    logic [32:0]      b_max_reg;
    logic [2:0]       b_neg_next;
    logic [2:0][32:0] b_mag_next;
    logic [32:0]      b_max_next;

    // Stage C: common normalization.
    logic             c_valid_reg, c_valid_next;
    logic [19:0]      c_center_reg;
    logic [2:0]       c_neg_reg;
    logic [2:0][30:0] c_mag_reg;
    logic [2:0][30:0] c_mag_next;
    logic [5:0]       c_msb;
    logic [5:0]       c_shift;

    // Stage D: squares.
    logic             d_valid_reg;
    logic [19:0]      d_center_reg;
    logic [2:0]       d_neg_reg;
    logic [2:0][30:0] d_mag_reg;
    logic [2:0][61:0] d_sq_reg;

    // Stage E: sum of squares.
    logic             e_valid_reg;
    logic [63:0]      e_sum_reg;
    tpf_pkg::side_t   e_side_reg;

    logic [24:0] center_ext;
    logic [24:0] atom_limit;

    assign center_ext = {5'b0, center_atom};
    assign atom_limit = 25'(ATOM_COUNT);
    assign a_valid_next = in_valid && (angle_kind == sel_type) && center_in_group
                          && (center_ext < atom_limit);

    // Valid bits of all stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    // Magnitudes and the largest of them.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_neg_next[i] = a_d_reg[i][32];
            b_mag_next[i] = b_neg_next[i] ? (33'd0 - a_d_reg[i]) : a_d_reg[i];
        end
        b_max_next = b_mag_next[0];
        if (b_mag_next[1] > b_max_next)
        begin
            b_max_next = b_mag_next[1];
        end
        if (b_mag_next[2] > b_max_next)
        begin
            b_max_next = b_mag_next[2];
        end
    end

    // Shift so that the largest magnitude lands in [2^30, 2^31).
    always_comb
    begin
        logic [64:0] wide;
        c_msb = 6'd0;
        for (int k = 0; k < 33; k++)
        begin
            if (b_max_reg[k])
            begin
                c_msb = 6'(k);
            end
        end
        c_shift = 6'd32 - c_msb;
        for (int i = 0; i < 3; i++)
        begin
            wide = {32'b0, b_mag_reg[i]} << c_shift;
            c_mag_next[i] = wide[32:2];
        end
        c_valid_next = b_valid_reg && (b_max_reg != 33'd0);
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_center_reg <= center_atom;
            a_d_reg[0]   <= {second_pos_x[31], second_pos_x} - {first_pos_x[31], first_pos_x};
            a_d_reg[1]   <= {second_pos_y[31], second_pos_y} - {first_pos_y[31], first_pos_y};
            a_d_reg[2]   <= {second_pos_z[31], second_pos_z} - {first_pos_z[31], first_pos_z};

            b_center_reg <= a_center_reg;
            b_neg_reg    <= b_neg_next;
            b_mag_reg    <= b_mag_next;
            b_max_reg    <= b_max_next;

            c_center_reg <= b_center_reg;
            c_neg_reg    <= b_neg_reg;
            c_mag_reg    <= c_mag_next;

            d_center_reg <= c_center_reg;
            d_neg_reg    <= c_neg_reg;
            d_mag_reg    <= c_mag_reg;
            for (int i = 0; i < 3; i++)
            begin
                d_sq_reg[i] <= c_mag_reg[i] * c_mag_reg[i];
            end

            e_sum_reg <= 64'(d_sq_reg[0]) + 64'(d_sq_reg[1]) + 64'(d_sq_reg[2]);
            e_side_reg.center <= d_center_reg;
            e_side_reg.neg    <= d_neg_reg;
            e_side_reg.mag    <= d_mag_reg;
        end
    end

    assign s_valid = e_valid_reg;
    assign s_sum   = e_sum_reg;
    assign s_side  = e_side_reg;

endmodule

[sv/tpf_sqrt.sv]
module tpf_sqrt (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [63:0]     in_sum,
    input  tpf_pkg::side_t  in_side,
    output logic            out_valid,
    output logic [31:0]     out_root,
    output tpf_pkg::side_t  out_side
);

    localparam int STAGES = tpf_pkg::SQRT_STAGES;

    logic           valid_reg [STAGES];
    logic [34:0]    rem_reg   [STAGES];
    logic [31:0]    res_reg   [STAGES];
    logic [63:0]    bits_reg  [STAGES];
    tpf_pkg::side_t side_reg  [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        logic           src_valid;
        logic [34:0]    src_rem;
        logic [31:0]    src_res;
        logic [63:0]    src_bits;
        tpf_pkg::side_t src_side;
        logic [34:0]    rem_next;
        logic [31:0]    res_next;
        logic [63:0]    bits_next;

        if (g == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = 35'd0;
            assign src_res   = 32'd0;
            assign src_bits  = in_sum;
            assign src_side  = in_side;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[g-1];
            assign src_rem   = rem_reg[g-1];
            assign src_res   = res_reg[g-1];
            assign src_bits  = bits_reg[g-1];
            assign src_side  = side_reg[g-1];
        end

        // Two digit-by-digit root steps, one bit pair each.
        always_comb
        begin
            logic [34:0] trial;
            rem_next  = src_rem;
            res_next  = src_res;
            bits_next = src_bits;
            for (int k = 0; k < tpf_pkg::SQRT_PER_STAGE; k++)
            begin
                rem_next  = {rem_next[32:0], bits_next[63:62]};
                trial     = {1'b0, res_next, 2'b01};
                bits_next = {bits_next[61:0], 2'b00};
                if (rem_next >= trial)
                begin
                    rem_next = rem_next - trial;
                    res_next = {res_next[30:0], 1'b1};
                end
                else
                begin
                    res_next = {res_next[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                res_reg[g]  <= res_next;
                bits_reg[g] <= bits_next;
                side_reg[g] <= src_side;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_root  = res_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

[sv/tpf_div.sv]
module tpf_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2:0][63:0] in_num,
    input  logic [31:0]      in_den,
    input  tpf_pkg::dside_t  in_side,
    output logic             out_valid,
    output logic [2:0][33:0] out_quot,
    output tpf_pkg::dside_t  out_side
);

    localparam int STAGES = tpf_pkg::DIV_STAGES;

    logic             valid_reg [STAGES];
    logic [2:0][32:0] rem_reg   [STAGES];
    logic [2:0][63:0] bits_reg  [STAGES];
    logic [2:0][33:0] quot_reg  [STAGES];
    logic [31:0]      den_reg   [STAGES];
    tpf_pkg::dside_t  side_reg  [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        logic             src_valid;
        logic [2:0][32:0] src_rem;
        logic [2:0][63:0] src_bits;
        logic [2:0][33:0] src_quot;
        logic [31:0]      src_den;
        tpf_pkg::dside_t  src_side;
        logic [2:0][32:0] rem_next;
        logic [2:0][63:0] bits_next;
        logic [2:0][33:0] quot_next;

        // The quotient fits in its bits since the numerator's high part is below the divisor.
        if (g == 0)
        begin : g_first
            always_comb
            begin
                for (int i = 0; i < 3; i++)
                begin
                    src_rem[i]  = {3'b0, in_num[i][63:34]};
                    src_bits[i] = {in_num[i][33:0], 30'b0};
                    src_quot[i] = 34'd0;
                end
            end
            assign src_valid = in_valid;
            assign src_den   = in_den;
            assign src_side  = in_side;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[g-1];
            assign src_rem   = rem_reg[g-1];
            assign src_bits  = bits_reg[g-1];
            assign src_quot  = quot_reg[g-1];
            assign src_den   = den_reg[g-1];
            assign src_side  = side_reg[g-1];
        end

        // Two restoring division steps for each component.
        always_comb
        begin
            logic [32:0] t;
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i]  = src_rem[i];
                bits_next[i] = src_bits[i];
                quot_next[i] = src_quot[i];
                for (int k = 0; k < tpf_pkg::DIV_PER_STAGE; k++)
                begin
                    t = {rem_next[i][31:0], bits_next[i][63]};
                    bits_next[i] = {bits_next[i][62:0], 1'b0};
                    if (t >= {1'b0, src_den})
                    begin
                        rem_next[i]  = t - {1'b0, src_den};
                        quot_next[i] = {quot_next[i][32:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i]  = t;
                        quot_next[i] = {quot_next[i][32:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[g] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                bits_reg[g] <= bits_next;
                quot_reg[g] <= quot_next;
                den_reg[g]  <= src_den;
                side_reg[g] <= src_side;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_quot  = quot_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule
